// ===== sv/cwcd_pkg.sv =====
// Shared types and constants of the capture word channel deinterleaver.
`default_nettype none

package cwcd_pkg;

  localparam int NumChan  = 4;
  localparam int CfgW     = 13;
  localparam int CfgIdxW  = 3;
  localparam int WordW    = 32;
  localparam int ChanW    = 2;

  localparam logic [WordW-1:0] DIGITAL_MASK = 32'h0101_0101;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_WORD  = 1'b1
  } cmd_e;

  typedef enum logic [ChanW-1:0] {
    CHAN_A = 2'd0,
    CHAN_B = 2'd1,
    CHAN_C = 2'd2,
    CHAN_D = 2'd3
  } chan_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORDS_A = 3'd0,
    REG_WORDS_B = 3'd1,
    REG_WORDS_C = 3'd2,
    REG_WORDS_D = 3'd3
  } reg_idx_e;

  // One finished group of four words, ready for the emitter.
  typedef struct packed {
    logic [NumChan-1:0][WordW-1:0] vals;
    logic [NumChan-1:0]            mask;
    logic                          done;
  } grp_t;

endpackage

`default_nettype wire

// ===== sv/cwcd_gather.sv =====
// Group assembly, channel extraction and per-channel word counters.
`default_nettype none

module cwcd_gather #(
  parameter int MAX_WORDS = 4096
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic [cwcd_pkg::NumChan-1:0][cwcd_pkg::CfgW-1:0] cfg_words_i,
  input  wire logic                                          in_valid_i,
  output logic                                               in_ready_o,
  input  wire logic                                          in_cmd_i,
  input  wire logic [cwcd_pkg::WordW-1:0]                    in_word_i,
  input  wire logic                                          load_ok_i,
  output logic                                               grp_valid_o,
  output cwcd_pkg::grp_t                                     grp_o
);
  import cwcd_pkg::*;

  localparam int CntW = $clog2(MAX_WORDS + 1);
  localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_WORDS);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_WORDS);

  logic [1:0]                        pos_q, pos_d;
  logic [2:0][WordW-1:0]             held_q;
  logic [NumChan-1:0][CntW-1:0]      rem_q, rem_d;
  logic [3:0][WordW-1:0]             grp_words;
  logic [2:0][WordW-1:0]             lane_bytes;
  logic [NumChan-1:0]                nonzero;
  logic                              accept, word_take, start_take;
  logic [WordW-1:0]                  byte2_gather;

  assign in_ready_o = (pos_q != 2'd3) || load_ok_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      nonzero[ch] = (rem_q[ch] != '0);
    end
  end

  assign start_take  = accept && (cmd_e'(in_cmd_i) == CMD_START);
  assign word_take   = accept && (cmd_e'(in_cmd_i) == CMD_WORD) && (|nonzero);
  assign grp_valid_o = word_take && (pos_q == 2'd3);

  assign grp_words[0] = held_q[0];
  assign grp_words[1] = held_q[1];
  assign grp_words[2] = held_q[2];
  assign grp_words[3] = in_word_i;

  always_comb begin
    for (int ln = 0; ln < 3; ln++) begin
      lane_bytes[ln] = {grp_words[0][8*ln +: 8], grp_words[1][8*ln +: 8],
                        grp_words[2][8*ln +: 8], grp_words[3][8*ln +: 8]};
    end
  end

  assign byte2_gather = lane_bytes[2];

  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    if (start_take) begin
      pos_d = '0;
      for (int ch = 0; ch < NumChan; ch++) begin
        if (CmpW'(cfg_words_i[ch]) > MaxCmp) begin
          rem_d[ch] = MaxCnt;
        end else begin
          rem_d[ch] = CntW'(cfg_words_i[ch]);
        end
      end
    end else if (word_take) begin
      pos_d = pos_q + 2'd1;
      if (pos_q == 2'd3) begin
        for (int ch = 0; ch < NumChan; ch++) begin
          rem_d[ch] = rem_q[ch] - CntW'(nonzero[ch]);
        end
      end
    end
  end

  always_comb begin
    grp_o.vals[CHAN_A] = lane_bytes[0];
    grp_o.vals[CHAN_B] = lane_bytes[1];
    grp_o.vals[CHAN_C] = byte2_gather & DIGITAL_MASK;
    grp_o.vals[CHAN_D] = (byte2_gather >> 1) & DIGITAL_MASK;
    grp_o.mask         = nonzero;
    grp_o.done         = 1'b1;
    for (int ch = 0; ch < NumChan; ch++) begin
      if (rem_d[ch] != '0) begin
        grp_o.done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rem_q <= '0;
    end else begin
      pos_q <= pos_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_take && (pos_q != 2'd3)) begin
      held_q[pos_q] <= in_word_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cwcd_emit.sv =====
// Result register; group packed words leave one a cycle while out_ready_i is high.
`default_nettype none

module cwcd_emit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         grp_valid_i,
  input  cwcd_pkg::grp_t                    grp_i,
  output logic                              load_ok_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cwcd_pkg::ChanW-1:0]        out_chan_o,
  output logic [cwcd_pkg::WordW-1:0]        out_word_o,
  output logic                              out_last_o,
  output logic                              out_done_o
);
  import cwcd_pkg::*;

  logic [NumChan-1:0]            mask_q, mask_d;
  logic [NumChan-1:0][WordW-1:0] vals_q;
  logic                          done_q;
  logic [NumChan-1:0]            sel_oh;
  logic                          out_hs;

  assign sel_oh = mask_q & (~mask_q + NumChan'(1));

  always_comb begin
    priority if (mask_q[CHAN_A]) out_chan_o = CHAN_A;
    else if (mask_q[CHAN_B])     out_chan_o = CHAN_B;
    else if (mask_q[CHAN_C])     out_chan_o = CHAN_C;
    else                         out_chan_o = CHAN_D;
  end

  assign out_valid_o = |mask_q;
  assign out_word_o  = vals_q[out_chan_o];
  assign out_last_o  = ((mask_q & ~sel_oh) == '0);
  assign out_done_o  = done_q;
  assign out_hs      = out_valid_o && out_ready_i;
  assign load_ok_o   = !out_valid_o || (out_hs && out_last_o);

  always_comb begin
    mask_d = mask_q;
    if (out_hs) begin
      mask_d = mask_q & ~sel_oh;
    end
    if (grp_valid_i) begin
      mask_d = grp_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_valid_i) begin
      vals_q <= grp_i.vals;
      done_q <= grp_i.done;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_i |-> load_ok_o)
    else $error("group loaded while earlier results still pending");

  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_i |-> (grp_i.mask != '0))
    else $error("finished group carries no channel");

  a_one_per_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && !grp_valid_i) |=> ($countones(mask_q) == $countones($past(mask_q)) - 1))
    else $error("handshake did not retire exactly one item");

  a_chan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mask_q[out_chan_o])
    else $error("selected channel has no pending item");

endmodule

`default_nettype wire

// ===== sv/capture_word_channel_deinterleave.sv =====
// Top level of the capture word channel deinterleaver.
`default_nettype none

// Capture FIFO words enter on s_axis; a start item (tuser 0) loads the per-channel
// word counts from the configuration registers, a word item (tuser 1) adds one
// FIFO word to the current group of four. The fourth word of a group produces one
// packed word for each channel whose count is still nonzero, in the order A, B,
// C, D, with tlast on the final one. Word items that arrive while all counts are
// zero are dropped. An item is taken every cycle but for the wait below; results
// of a group leave one per cycle while m_axis_tready is high, from a result register,
// and a new group can be loaded into it in the cycle its last result is taken, so
// a steady stream of four-channel captures runs at one item per cycle while the
// downstream side keeps up. Only an item that arrives while three words of a group
// are held waits, and only while earlier results are still held by the downstream side.
module capture_word_channel_deinterleave #(
  parameter int MAX_WORDS = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cwcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cwcd_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // fifo_word
  input  wire logic [0:0]                    s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // packed_word, capture_done, zeros
  output logic [1:0]                         m_axis_tuser,  // channel
  output logic                               m_axis_tlast   // last_of_group
);
  import cwcd_pkg::*;

  logic [NumChan-1:0][CfgW-1:0] cfg_q;
  logic                         grp_valid;
  grp_t                         grp;
  logic                         load_ok;
  logic [WordW-1:0]             out_word;
  logic                         out_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WORDS_A: cfg_q[CHAN_A] <= cfg_data_i;
        REG_WORDS_B: cfg_q[CHAN_B] <= cfg_data_i;
        REG_WORDS_C: cfg_q[CHAN_C] <= cfg_data_i;
        REG_WORDS_D: cfg_q[CHAN_D] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cwcd_gather #(
    .MAX_WORDS (MAX_WORDS)
  ) u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_words_i (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_word_i   (s_axis_tdata),
    .load_ok_i   (load_ok),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  cwcd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .load_ok_o   (load_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chan_o  (m_axis_tuser),
    .out_word_o  (out_word),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (out_done)
  );

  assign m_axis_tdata = {7'b0, out_done, out_word};

endmodule

`default_nettype wire
